// ===== rtl/core/srtf_pkg.sv =====
// Package for the SRTF scheduler: status codes, field widths and default sizes.
// No dependencies; used by srtf_if and srtf_preemptive_scheduler.
package srtf_pkg;
    localparam int HEAP_DEPTH_DEF = 64;
    localparam int ID_BITS_DEF    = 8;
    localparam int BURST_BITS_DEF = 16;

    localparam int ID_W     = 8;
    localparam int BURST_W  = 16;
    localparam int STATUS_W = 3;
    localparam int TIME_W   = 32;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RUN    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd4;
endpackage

// ===== rtl/core/srtf_if.sv =====
// Request and result channel interfaces for the SRTF scheduler.
// Depends on srtf_pkg for the field widths.
interface srtf_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [srtf_pkg::ID_W-1:0]    job_id;
    logic [srtf_pkg::BURST_W-1:0] burst;
    modport source (output valid, op, job_id, burst, input ready);
    modport sink   (input valid, op, job_id, burst, output ready);
endinterface

interface srtf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [srtf_pkg::STATUS_W-1:0] status;
    logic [srtf_pkg::ID_W-1:0]     done_id;
    logic [srtf_pkg::TIME_W-1:0]   turnaround;
    logic [srtf_pkg::TIME_W-1:0]   waiting;
    logic [srtf_pkg::ID_W-1:0]     running_id;
    logic                          running_valid;
    modport source (output valid, status, done_id, turnaround, waiting, running_id,
                    running_valid, input ready);
    modport sink   (input valid, status, done_id, turnaround, waiting, running_id,
                    running_valid, output ready);
endinterface

// ===== rtl/core/srtf_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/srtf_preemptive_scheduler.sv =====
// Preemptive shortest-remaining-time-first scheduler with a binary min-heap in RAM.
// Depends on srtf_pkg, srtf_if (request and result channels) and srtf_ram.
// Each request is decoded first; an arrival that joins the heap then runs an insert sift.
// A tick adds an insert and an extract on preemption, plus a record read and another extract
// on completion. One request at a time; the next is taken the cycle after the result goes.
// Reset clears job, time and count, not RAMs.
module srtf_preemptive_scheduler #(
    parameter int HEAP_DEPTH = srtf_pkg::HEAP_DEPTH_DEF,
    parameter int ID_BITS    = srtf_pkg::ID_BITS_DEF,
    parameter int BURST_BITS = srtf_pkg::BURST_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    srtf_req_if.sink    req,
    srtf_rsp_if.source  rsp
);
    // The heap keeps one spare slot for the running job pushed during preemption.
    localparam int SLOTS = HEAP_DEPTH + 1;
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int KW    = BURST_BITS + ID_BITS;
    localparam int JW    = srtf_pkg::TIME_W + BURST_BITS;
    localparam int TW    = srtf_pkg::TIME_W;
    localparam int IDS   = 1 << ID_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE,
        S_PUSH_RD, S_PUSH_WT, S_PUSH_CMP,
        S_POP_LAST, S_POP_LWT, S_POP_L, S_POP_LCMP, S_POP_RWT, S_POP_RCMP,
        S_AFTER, S_JOB_RD, S_JOB_WT, S_RESULT
    } state_t;

    // What the sequencer does once a push or pop sift has finished.
    typedef enum logic [1:0] {
        K_ARRIVE, K_PREEMPT_POP, K_PULL_TICK, K_PULL_DONE
    } cont_t;

    state_t state_reg;
    cont_t  cont_reg;

    logic                  cur_valid_reg;
    logic [ID_BITS-1:0]    cur_id_reg;
    logic [BURST_BITS-1:0] cur_rem_reg;
    logic [TW-1:0]         time_reg;
    logic [CW-1:0]         count_reg;
    logic [BURST_BITS-1:0] root_rem_reg;
    logic                  root_ok_reg;

    logic                  op_reg;
    logic [ID_BITS-1:0]    in_id_reg;
    logic [BURST_BITS-1:0] in_burst_reg;

    // Sift working registers: the moving key and the slot it currently sits in.
    logic [KW-1:0] key_reg;
    logic [AW-1:0] idx_reg;
    logic [KW-1:0] best_reg;
    logic [AW-1:0] best_idx_reg;
    logic [KW-1:0] top_reg;

    logic                          out_valid_reg;
    logic [srtf_pkg::STATUS_W-1:0] out_status_reg;
    logic [srtf_pkg::ID_W-1:0]     out_done_reg;
    logic [TW-1:0]                 out_turn_reg;
    logic [TW-1:0]                 out_wait_reg;
    logic [ID_BITS-1:0]            done_id_reg;

    logic          h_we;
    logic [AW-1:0] h_waddr;
    logic [KW-1:0] h_wdata;
    logic [AW-1:0] h_raddr;
    logic [KW-1:0] h_rdata;

    logic          j_we;
    logic [ID_BITS-1:0] j_waddr;
    logic [JW-1:0] j_wdata;
    logic [ID_BITS-1:0] j_raddr;
    logic [JW-1:0] j_rdata;

    srtf_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_heap (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    srtf_ram #(.WIDTH(JW), .DEPTH(IDS)) u_jobs (
        .clk(clk), .we(j_we), .waddr(j_waddr), .wdata(j_wdata),
        .raddr(j_raddr), .rdata(j_rdata)
    );

    logic [AW-1:0] parent_idx;
    logic [AW:0]   left_w;
    logic [AW:0]   right_w;
    logic [CW-1:0] last_cnt;
    logic [BURST_BITS-1:0] dec_rem;

    assign parent_idx = AW'((idx_reg - 1'b1) >> 1);
    assign left_w     = {idx_reg, 1'b1};
    assign right_w    = {idx_reg, 1'b0} + (AW+1)'(2);
    assign last_cnt   = count_reg - 1'b1;
    assign dec_rem    = cur_rem_reg - 1'b1;

    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.done_id = out_done_reg;
    assign rsp.turnaround = out_turn_reg;
    assign rsp.waiting = out_wait_reg;
    assign rsp.running_id = cur_valid_reg ? srtf_pkg::ID_W'(cur_id_reg) : '0;
    assign rsp.running_valid = cur_valid_reg;

    // Memory port control is a function of the state and the working registers.
    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = idx_reg;
        h_wdata = key_reg;
        h_raddr = '0;
        j_we    = 1'b0;
        j_waddr = in_id_reg;
        j_wdata = {time_reg, in_burst_reg};
        j_raddr = done_id_reg;
        case (state_reg)
            S_IDLE:
            begin
                h_raddr = '0;
            end
            S_DECODE:
            begin
                h_raddr = '0;
                j_we = (op_reg == srtf_pkg::OP_ARRIVE) && (in_burst_reg != '0)
                       && !(cur_valid_reg && count_reg >= CW'(HEAP_DEPTH));
            end
            S_PUSH_RD:
            begin
                h_raddr = parent_idx;
            end
            S_PUSH_WT:
            begin
                // Hold the parent address so its data is still on the port for the compare.
                h_raddr = parent_idx;
            end
            S_PUSH_CMP:
            begin
                // Either the parent moves down into this slot or the key settles here.
                h_we = 1'b1;
                if (idx_reg != '0 && h_rdata[KW-1 -: BURST_BITS] > key_reg[KW-1 -: BURST_BITS])
                begin
                    h_wdata = h_rdata;
                end
            end
            S_POP_LAST:
            begin
                h_raddr = AW'(last_cnt);
            end
            S_POP_L:
            begin
                h_raddr = AW'(left_w);
            end
            S_POP_LCMP:
            begin
                h_raddr = AW'(right_w);
            end
            S_POP_RCMP:
            begin
                // The chosen child moves up, or the key settles here.
                h_we = 1'b1;
                if (best_idx_reg != idx_reg)
                begin
                    h_wdata = best_reg;
                end
            end
            S_AFTER:
            begin
                h_raddr = '0;
            end
            default:
            begin
                h_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cont_reg       <= K_ARRIVE;
            cur_valid_reg  <= 1'b0;
            cur_id_reg     <= '0;
            cur_rem_reg    <= '0;
            time_reg       <= '0;
            count_reg      <= '0;
            root_ok_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= srtf_pkg::ST_IDLE;
            out_done_reg   <= '0;
            out_turn_reg   <= '0;
            out_wait_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.ready)
                    begin
                        op_reg       <= req.op;
                        in_id_reg    <= req.job_id[ID_BITS-1:0];
                        in_burst_reg <= req.burst[BURST_BITS-1:0];
                        state_reg    <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    // Heap root (h_rdata valid now) is read for preemption checks.
                    root_rem_reg <= h_rdata[KW-1 -: BURST_BITS];
                    out_done_reg <= '0;
                    out_turn_reg <= '0;
                    out_wait_reg <= '0;
                    if (op_reg == srtf_pkg::OP_ARRIVE)
                    begin
                        if (in_burst_reg == '0
                            || (cur_valid_reg && count_reg >= CW'(HEAP_DEPTH)))
                        begin
                            out_status_reg <= srtf_pkg::ST_REJECT;
                            state_reg      <= S_RESULT;
                        end
                        else if (!cur_valid_reg)
                        begin
                            cur_valid_reg  <= 1'b1;
                            cur_id_reg     <= in_id_reg;
                            cur_rem_reg    <= in_burst_reg;
                            out_status_reg <= srtf_pkg::ST_ACCEPT;
                            state_reg      <= S_RESULT;
                        end
                        else
                        begin
                            out_status_reg <= srtf_pkg::ST_ACCEPT;
                            key_reg   <= {in_burst_reg, in_id_reg};
                            idx_reg   <= AW'(count_reg);
                            count_reg <= count_reg + 1'b1;
                            cont_reg  <= K_ARRIVE;
                            state_reg <= S_PUSH_RD;
                        end
                    end
                    else if (!cur_valid_reg)
                    begin
                        if (count_reg != '0)
                        begin
                            top_reg   <= h_rdata;
                            cont_reg  <= K_PULL_TICK;
                            state_reg <= S_POP_LAST;
                        end
                        else
                        begin
                            time_reg       <= time_reg + 1'b1;
                            out_status_reg <= srtf_pkg::ST_IDLE;
                            state_reg      <= S_RESULT;
                        end
                    end
                    else
                    begin
                        root_ok_reg <= 1'b1;
                        state_reg   <= S_AFTER;
                    end
                end
                S_PUSH_RD:
                begin
                    state_reg <= S_PUSH_WT;
                end
                S_PUSH_WT:
                begin
                    state_reg <= S_PUSH_CMP;
                end
                S_PUSH_CMP:
                begin
                    if (idx_reg != '0
                        && h_rdata[KW-1 -: BURST_BITS] > key_reg[KW-1 -: BURST_BITS])
                    begin
                        idx_reg   <= parent_idx;
                        state_reg <= S_PUSH_RD;
                    end
                    else if (cont_reg == K_PREEMPT_POP)
                    begin
                        state_reg <= S_POP_LAST;
                    end
                    else
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_POP_LAST:
                begin
                    // Root read for the top of the heap was issued earlier; read last.
                    state_reg <= S_POP_LWT;
                end
                S_POP_LWT:
                begin
                    key_reg   <= h_rdata;
                    idx_reg   <= '0;
                    count_reg <= last_cnt;
                    if (last_cnt == '0)
                    begin
                        state_reg <= S_AFTER;
                    end
                    else
                    begin
                        state_reg <= S_POP_L;
                    end
                end
                S_POP_L:
                begin
                    best_reg     <= key_reg;
                    best_idx_reg <= idx_reg;
                    state_reg    <= S_POP_LCMP;
                end
                S_POP_LCMP:
                begin
                    if (left_w < (AW+1)'(count_reg)
                        && h_rdata[KW-1 -: BURST_BITS] < key_reg[KW-1 -: BURST_BITS])
                    begin
                        best_reg     <= h_rdata;
                        best_idx_reg <= AW'(left_w);
                    end
                    state_reg <= S_POP_RWT;
                end
                S_POP_RWT:
                begin
                    if (right_w < (AW+1)'(count_reg)
                        && h_rdata[KW-1 -: BURST_BITS] < best_reg[KW-1 -: BURST_BITS])
                    begin
                        best_reg     <= h_rdata;
                        best_idx_reg <= AW'(right_w);
                    end
                    state_reg <= S_POP_RCMP;
                end
                S_POP_RCMP:
                begin
                    if (best_idx_reg != idx_reg)
                    begin
                        idx_reg   <= best_idx_reg;
                        state_reg <= S_POP_L;
                    end
                    else
                    begin
                        state_reg <= S_AFTER;
                    end
                end
                S_AFTER:
                begin
                    // A pop has just finished when root_ok_reg is clear.
                    case (cont_reg)
                        K_PREEMPT_POP:
                        begin
                            if (!root_ok_reg)
                            begin
                                cur_id_reg  <= top_reg[ID_BITS-1:0];
                                cur_rem_reg <= top_reg[KW-1 -: BURST_BITS];
                                root_ok_reg <= 1'b1;
                                cont_reg    <= K_ARRIVE;
                            end
                        end
                        K_PULL_TICK:
                        begin
                            if (!root_ok_reg)
                            begin
                                cur_valid_reg <= 1'b1;
                                cur_id_reg    <= top_reg[ID_BITS-1:0];
                                cur_rem_reg   <= top_reg[KW-1 -: BURST_BITS];
                                root_ok_reg   <= 1'b1;
                                cont_reg      <= K_ARRIVE;
                            end
                        end
                        K_PULL_DONE:
                        begin
                            cur_valid_reg <= 1'b1;
                            cur_id_reg    <= top_reg[ID_BITS-1:0];
                            cur_rem_reg   <= top_reg[KW-1 -: BURST_BITS];
                            state_reg     <= S_JOB_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (cont_reg != K_PULL_DONE && (root_ok_reg || cont_reg == K_ARRIVE))
                    begin
                        if (root_ok_reg && cont_reg == K_ARRIVE && count_reg != '0
                            && root_rem_reg < cur_rem_reg)
                        begin
                            // Preempt: push the running job, then pop the root.
                            root_ok_reg <= 1'b0;
                            top_reg     <= '0;
                            key_reg     <= {cur_rem_reg, cur_id_reg};
                            idx_reg     <= AW'(count_reg);
                            count_reg   <= count_reg + 1'b1;
                            cont_reg    <= K_PREEMPT_POP;
                            state_reg   <= S_PUSH_RD;
                        end
                        else
                        begin
                            cur_rem_reg <= dec_rem;
                            time_reg    <= time_reg + 1'b1;
                            root_ok_reg <= 1'b0;
                            if (dec_rem == '0)
                            begin
                                done_id_reg   <= cur_id_reg;
                                cur_valid_reg <= 1'b0;
                                state_reg     <= S_JOB_RD;
                            end
                            else
                            begin
                                out_status_reg <= srtf_pkg::ST_RUN;
                                state_reg      <= S_RESULT;
                            end
                        end
                    end
                end
                S_JOB_RD:
                begin
                    state_reg <= S_JOB_WT;
                end
                S_JOB_WT:
                begin
                    out_status_reg <= srtf_pkg::ST_DONE;
                    out_done_reg   <= srtf_pkg::ID_W'(done_id_reg);
                    out_turn_reg   <= time_reg - j_rdata[JW-1 -: TW];
                    out_wait_reg   <= time_reg - j_rdata[JW-1 -: TW]
                                      - TW'(j_rdata[BURST_BITS-1:0]);
                    if (cont_reg != K_PULL_DONE && count_reg != '0)
                    begin
                        cont_reg  <= K_PULL_DONE;
                        state_reg <= S_POP_LAST;
                    end
                    else
                    begin
                        cont_reg  <= K_ARRIVE;
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    out_valid_reg <= 1'b1;
                    cont_reg      <= K_ARRIVE;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            // The pop sequence reads the root at its start: capture it for the popped job.
            if (state_reg == S_POP_LAST && cont_reg != K_PULL_TICK)
            begin
                top_reg <= h_rdata;
            end
        end
    end
endmodule
